@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, entry and control types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 16;
   localparam int TAG_BITS   = 16;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CAP_BITS   = 5;
   localparam int COUNT_BITS = 5;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [CAP_BITS-1:0]  CAP_RESET    = CAP_BITS'(16);
   localparam logic [ADDR_BITS-3:0] REG_CAPACITY = '0;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } ctrl_type;

endpackage

@@ rtl/spq_if.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channel interfaces with valid and ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [KEY_BITS-1:0] priority_req;
   logic [TAG_BITS-1:0] tag;

   modport source (output valid, output opcode, output priority_req, output tag,
                   input ready);
   modport sink   (input valid, input opcode, input priority_req, input tag,
                   output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  out_valid;
   logic [KEY_BITS-1:0]   out_priority;
   logic [TAG_BITS-1:0]   out_tag;
   logic                  rejected;
   logic [COUNT_BITS-1:0] entry_count;
   logic                  is_empty;
   logic                  is_full;

   modport source (output valid, output out_valid, output out_priority,
                   output out_tag, output rejected, output entry_count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input out_valid, input out_priority,
                   input out_tag, input rejected, input entry_count,
                   input is_empty, input is_full, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: compares, holds, or takes the new item or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  ctrl_type  ctrl,
   input  logic      occupied,
   input  logic      prev_ge,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output entry_type entry,
   output logic      ge
);

   entry_type entry_ff;
   entry_type entry_in;

   assign ge    = occupied && (entry_ff.key >= ctrl.item.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq && !ge) begin
         entry_in = prev_ge ? ctrl.item : left_entry;
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/spq_csr.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue register port
// APB-style access to the capacity register.
// ----------------------------------------------------------------------------
module spq_csr
   import spq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output logic [CAP_BITS-1:0]  capacity
);

   logic [CAP_BITS-1:0] capacity_ff;
   logic [CAP_BITS-1:0] capacity_in;
   logic                hit;

   assign hit        = (csr_paddr[ADDR_BITS-1:2] == REG_CAPACITY);
   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? DATA_BITS'(capacity_ff) : '0;
   assign capacity   = capacity_ff;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         capacity_in = csr_pwdata[CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept in descending priority order by a chain of cells.
// ----------------------------------------------------------------------------
// Every cell compares its entry with an incoming key in the same cycle, so
// the queue takes one enqueue or dequeue transfer per clock cycle and
// answers it in the following cycle from the response register. A new
// transfer is taken while the response register is empty or being drained.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   spq_req_if.sink              req_chan,
   spq_rsp_if.source            rsp_chan,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   logic [CAP_BITS-1:0] capacity;
   logic [CNT_BITS-1:0] eff_cap;
   logic [CNT_BITS-1:0] held_ff;
   logic [CNT_BITS-1:0] held_in;
   logic                accept;
   logic                is_deq;
   logic                reject;
   ctrl_type            ctrl;
   entry_type           cell_entry [DEPTH];
   logic                cell_ge    [DEPTH];

   logic                  rsp_valid_ff,   rsp_valid_in;
   logic                  out_valid_ff,   out_valid_in;
   entry_type             out_entry_ff,   out_entry_in;
   logic                  rejected_ff,    rejected_in;
   logic [COUNT_BITS-1:0] count_ff,       count_in;
   logic                  empty_ff,       empty_in;
   logic                  full_ff,        full_in;

   spq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   always_comb begin
      if (capacity == '0) begin
         eff_cap = CNT_BITS'(1);
      end else if (32'(capacity) > DEPTH) begin
         eff_cap = CNT_BITS'(DEPTH);
      end else begin
         eff_cap = CNT_BITS'(capacity);
      end
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_deq         = (opcode_type'(req_chan.opcode) == OP_DEQUEUE);
   assign reject         = is_deq ? (held_ff == '0) : (held_ff >= eff_cap);

   assign ctrl.enq       = accept && !is_deq && !reject;
   assign ctrl.deq       = accept && is_deq && !reject;
   assign ctrl.item.key  = req_chan.priority_req;
   assign ctrl.item.tag  = req_chan.tag;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      prev_ge;

      if (i == 0) begin : g_head
         assign left_entry = ctrl.item;
         assign prev_ge    = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign prev_ge    = cell_ge[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_BITS'(i) < held_ff),
         .prev_ge     (prev_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   always_comb begin
      held_in = held_ff;
      if (ctrl.enq) begin
         held_in = held_ff + CNT_BITS'(1);
      end else if (ctrl.deq) begin
         held_in = held_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_valid_in = out_valid_ff;
      out_entry_in = out_entry_ff;
      rejected_in  = rejected_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_valid_in = ctrl.deq;
         out_entry_in = ctrl.deq ? cell_entry[0] : '0;
         rejected_in  = reject;
         count_in     = COUNT_BITS'(held_in);
         empty_in     = (held_in == '0);
         full_in      = (held_in >= eff_cap);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_entry_ff <= out_entry_in;
      rejected_ff  <= rejected_in;
      count_ff     <= count_in;
      empty_ff     <= empty_in;
      full_ff      <= full_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_valid    = out_valid_ff;
   assign rsp_chan.out_priority = out_entry_ff.key;
   assign rsp_chan.out_tag      = out_entry_ff.tag;
   assign rsp_chan.rejected     = rejected_ff;
   assign rsp_chan.entry_count  = count_ff;
   assign rsp_chan.is_empty     = empty_ff;
   assign rsp_chan.is_full      = full_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      32'(held_ff) <= DEPTH)
      else $error("Held count exceeds the chain depth.");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.deq |=> held_ff == $past(held_ff) - CNT_BITS'(1))
      else $error("Dequeue did not lower the held count by one.");

   a_result_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_valid_ff && rejected_ff))
      else $error("Response both returns an entry and reports a rejection.");

   a_enq_order: assert property (@(posedge clock) disable iff (reset)
      (ctrl.enq && held_ff != '0 && !cell_ge[0]) |=>
         cell_entry[0].key == $past(req_chan.priority_req))
      else $error("Higher priority enqueue did not reach the head cell.");

endmodule
